>>> rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and constants for the terrain slope / aspect block
// Widths, fixed-point constants, the arctangent table and the sideband
// record that travels with each beat through the CORDIC cells.
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam int ELEV_W          = 32;
	localparam int MASK_W          = 8;
	localparam int SAMPLE_BITS     = 32;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int OUT_W           = 25;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int STEPS   = 30;
	localparam int STEP_W  = 5;
	localparam int SUM_W   = 35;
	localparam int MAG_W   = 34;
	localparam int PROD_W  = 66;
	localparam int VEC_W   = 64;
	localparam int Z_W     = 34;
	localparam int A_W     = 36;
	localparam int ANG_W   = 33;
	localparam int BLEN_W  = 7;

	localparam logic [BLEN_W-1:0] REF_BLEN  = 7'd20;
	localparam logic [BLEN_W-1:0] NORM_TOP  = 7'd60;
	localparam logic [BLEN_W-1:0] REF_EXP   = 7'd79;
	localparam logic [BLEN_W-1:0] GAIN_EXP  = 7'd30;
	localparam int                ASP_SHIFT = 26;

	localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
	localparam logic [29:0] DEG_Q24  = 30'd961263669;

	localparam logic signed [A_W-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [A_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [A_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

	localparam logic [63:0] RND_DEG = 64'd1 << (53 - ANGLE_FRAC_BITS);
	localparam logic [Z_W-1:0] RND_RAD = 34'd1 << (29 - ANGLE_FRAC_BITS);
	localparam int SH_DEG = 54 - ANGLE_FRAC_BITS;
	localparam int SH_RAD = 30 - ANGLE_FRAC_BITS;
	localparam logic [OUT_W-1:0] ANGLE_MAX = {OUT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_DEGREES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Y  = 2'd3;

	localparam logic [29:0] ATAN_Q30 [STEPS] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
		30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
		30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
		30'd31, 30'd15, 30'd7, 30'd3, 30'd1
	};

	typedef enum logic [1:0] {
		OFF_ZERO   = 2'b00,
		OFF_POS_PI = 2'b01,
		OFF_NEG_PI = 2'b10
	} off_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [Z_W-1:0]   z;
	} vec_t;

	typedef struct packed {
		logic              is_null;
		off_t              off;
		logic [BLEN_W-1:0] blen;
		logic [ANG_W-1:0]  ang;
	} tag_t;

endpackage

>>> rtl/tsa_if.sv
// ----------------------------------------------------------------------------
// tsa_if: window and result channels
// Valid/ready channels carrying one 3x3 window beat and one angle beat.
// ----------------------------------------------------------------------------
interface tsa_win_if import tsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ELEV_W-1:0] elev_nw;
	logic [ELEV_W-1:0] elev_n;
	logic [ELEV_W-1:0] elev_ne;
	logic [ELEV_W-1:0] elev_w;
	logic [ELEV_W-1:0] elev_e;
	logic [ELEV_W-1:0] elev_sw;
	logic [ELEV_W-1:0] elev_s;
	logic [ELEV_W-1:0] elev_se;
	logic [MASK_W-1:0] special_mask;

	modport source (output valid, elev_nw, elev_n, elev_ne, elev_w, elev_e,
		elev_sw, elev_s, elev_se, special_mask, input ready);
	modport sink (input valid, elev_nw, elev_n, elev_ne, elev_w, elev_e,
		elev_sw, elev_s, elev_se, special_mask, output ready);
endinterface

interface tsa_res_if import tsa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] angle;
	logic             is_null;

	modport source (output valid, angle, is_null, input ready);
	modport sink (input valid, angle, is_null, output ready);
endinterface

>>> rtl/tsa_cordic_cell.sv
// ----------------------------------------------------------------------------
// tsa_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the vector towards the x axis by the step angle and registers the
// result together with its sideband record.
// ----------------------------------------------------------------------------
module tsa_cordic_cell import tsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  logic              up_vld,
	input  vec_t              up_vec,
	input  tag_t              up_tag,
	output logic              dn_vld,
	output vec_t              dn_vec,
	output tag_t              dn_tag
);

	logic                    vld_q;
	vec_t                    vec_q;
	tag_t                    tag_q;
	vec_t                    nv;
	logic signed [VEC_W-1:0] dx;
	logic signed [VEC_W-1:0] dy;
	logic signed [Z_W-1:0]   at;

	always_comb begin
		dx = up_vec.y >>> step;
		dy = up_vec.x >>> step;
		at = $signed(Z_W'(ATAN_Q30[step]));
		if (up_vec.y >= 0) begin
			nv.x = up_vec.x + dx;
			nv.y = up_vec.y - dy;
			nv.z = up_vec.z + at;
		end else begin
			nv.x = up_vec.x - dx;
			nv.y = up_vec.y + dy;
			nv.z = up_vec.z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= up_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= nv;
			tag_q <= up_tag;
		end
	end

	assign dn_vld = vld_q;
	assign dn_vec = vec_q;
	assign dn_tag = tag_q;

endmodule

>>> rtl/tsa_cordic_chain.sv
// ----------------------------------------------------------------------------
// tsa_cordic_chain: row of CORDIC cells
// Full vectoring pass, one micro-rotation per cell, one beat per cycle while en is high.
// ----------------------------------------------------------------------------
module tsa_cordic_chain import tsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic up_vld,
	input  vec_t up_vec,
	input  tag_t up_tag,
	output logic dn_vld,
	output vec_t dn_vec,
	output tag_t dn_tag
);

	logic vld [STEPS+1];
	vec_t vec [STEPS+1];
	tag_t tag [STEPS+1];

	assign vld[0] = up_vld;
	assign vec[0] = up_vec;
	assign tag[0] = up_tag;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		tsa_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (STEP_W'(i)),
			.up_vld (vld[i]),
			.up_vec (vec[i]),
			.up_tag (tag[i]),
			.dn_vld (vld[i+1]),
			.dn_vec (vec[i+1]),
			.dn_tag (tag[i+1])
		);
	end

	assign dn_vld = vld[STEPS];
	assign dn_vec = vec[STEPS];
	assign dn_tag = tag[STEPS];

endmodule

>>> rtl/terrain_slope_aspect_3x3.sv
// ----------------------------------------------------------------------------
// terrain_slope_aspect_3x3: Horn slope / compass aspect of a 3x3 window
// Horn gradients, cell-size scaling and two CORDIC vectoring chains.
// ----------------------------------------------------------------------------
// Usage
//   win carries the eight neighbour elevations and the invalid-sample mask,
//   res returns one angle beat (unsigned Q9.16, radians or degrees) and the
//   null flag for every window beat, in order.
//   Registers are to be written through cfg_we / cfg_index / cfg_wdata only
//   while the block holds no work; the block itself does not enforce this.
// Pipeline and throughput
//   A window beat passes five front stages (Horn sums, scaling products,
//   sum, leading-one search, normalise), two chains of 30 CORDIC cells
//   with one stage between them, two conversion stages and the output
//   register. One beat is taken every cycle while the skid register is empty.
// Reset
//   arst_n empties the pipeline and loads the register defaults (slope,
//   radians, unit reciprocal cell sizes).
// Stalls
//   A skid register behind the output register catches the beat in flight;
//   while it is full win.ready is low and the whole pipeline holds.
// ----------------------------------------------------------------------------
module terrain_slope_aspect_3x3 import tsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	tsa_win_if.sink               win,
	tsa_res_if.source             res
);

	function automatic logic signed [SUM_W-1:0] sext(input logic [ELEV_W-1:0] v);
		return SUM_W'($signed(v[SAMPLE_BITS-1:0]));
	endfunction

	logic        mode_q;
	logic        deg_q;
	logic [31:0] inv_x_q;
	logic [31:0] inv_y_q;
	logic        en;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			deg_q   <= 1'b0;
			inv_x_q <= 32'd65536;
			inv_y_q <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OUTPUT_MODE: mode_q  <= cfg_wdata[0];
				CFG_IN_DEGREES:  deg_q   <= cfg_wdata[0];
				CFG_INV_CELL_X:  inv_x_q <= cfg_wdata;
				CFG_INV_CELL_Y:  inv_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage 1: horn sums
	logic signed [SUM_W-1:0] sx;
	logic signed [SUM_W-1:0] sy;
	logic signed [SUM_W-1:0] sx_s1;
	logic signed [SUM_W-1:0] sy_s1;
	logic                    null_s1;
	logic                    vld_s1;

	always_comb begin
		sx = (sext(win.elev_ne) + (sext(win.elev_e) <<< 1) + sext(win.elev_se))
			- (sext(win.elev_nw) + (sext(win.elev_w) <<< 1) + sext(win.elev_sw));
		sy = (sext(win.elev_sw) + (sext(win.elev_s) <<< 1) + sext(win.elev_se))
			- (sext(win.elev_nw) + (sext(win.elev_n) <<< 1) + sext(win.elev_ne));
	end

	// stage 2: magnitude products and aspect vector
	logic signed [SUM_W-1:0] magx;
	logic signed [SUM_W-1:0] magy;
	logic signed [SUM_W-1:0] ax;
	logic signed [SUM_W-1:0] ay;
	off_t                    off;
	logic [63:0]             pxl_s2;
	logic [63:0]             pyl_s2;
	logic [1:0]              pxh_s2;
	logic [1:0]              pyh_s2;
	logic signed [VEC_W-1:0] ax_s2;
	logic signed [VEC_W-1:0] ay_s2;
	tag_t                    tag_s2;
	logic                    vld_s2;

	always_comb begin
		magx = (sx_s1 < 0) ? -sx_s1 : sx_s1;
		magy = (sy_s1 < 0) ? -sy_s1 : sy_s1;
		ax   = -sx_s1;
		ay   = sy_s1;
		off  = OFF_ZERO;
		if (ax < 0) begin
			off = (ay >= 0) ? OFF_POS_PI : OFF_NEG_PI;
			ax  = -ax;
			ay  = -ay;
		end
	end

	// stage 3: full products
	logic [33:0]             hx;
	logic [33:0]             hy;
	logic [PROD_W-1:0]       px_s3;
	logic [PROD_W-1:0]       py_s3;
	logic signed [VEC_W-1:0] ax_s3;
	logic signed [VEC_W-1:0] ay_s3;
	tag_t                    tag_s3;
	logic                    vld_s3;

	assign hx = 34'(pxh_s2) * 34'(inv_x_q);
	assign hy = 34'(pyh_s2) * 34'(inv_y_q);

	// stage 4: common bit length
	logic [PROD_W-1:0]       orv;
	logic [BLEN_W-1:0]       bl;
	logic [PROD_W-1:0]       px_s4;
	logic [PROD_W-1:0]       py_s4;
	logic signed [VEC_W-1:0] ax_s4;
	logic signed [VEC_W-1:0] ay_s4;
	tag_t                    tag_s4;
	logic                    vld_s4;

	always_comb begin
		orv = px_s3 | py_s3;
		bl  = REF_BLEN;
		for (int i = 0; i < PROD_W; i++) begin
			if (orv[i] && (BLEN_W'(i + 1) > bl)) begin
				bl = BLEN_W'(i + 1);
			end
		end
	end

	// stage 5: normalise, chain a input
	logic [VEC_W-1:0] nx;
	logic [VEC_W-1:0] ny;
	vec_t             va_s5;
	tag_t             tag_s5;
	logic             vld_s5;

	always_comb begin
		if (tag_s4.blen > NORM_TOP) begin
			nx = VEC_W'(px_s4 >> (tag_s4.blen - NORM_TOP));
			ny = VEC_W'(py_s4 >> (tag_s4.blen - NORM_TOP));
		end else begin
			nx = VEC_W'(px_s4 << (NORM_TOP - tag_s4.blen));
			ny = VEC_W'(py_s4 << (NORM_TOP - tag_s4.blen));
		end
	end

	logic vld_a;
	vec_t vec_a;
	tag_t tag_a;

	tsa_cordic_chain u_chain_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.up_vld (vld_s5),
		.up_vec (va_s5),
		.up_tag (tag_s5),
		.dn_vld (vld_a),
		.dn_vec (vec_a),
		.dn_tag (tag_a)
	);

	// stage 6: reference vector for chain b, compass mapping
	logic [BLEN_W-1:0]     ex;
	logic [VEC_W-1:0]      rk;
	logic signed [A_W-1:0] offv;
	logic signed [A_W-1:0] a;
	logic signed [A_W-1:0] c;
	tag_t                  tag_m;
	vec_t                  vb_s6;
	tag_t                  tag_s6;
	logic                  vld_s6;

	always_comb begin
		ex = REF_EXP - tag_a.blen;
		if (ex >= GAIN_EXP) begin
			rk = VEC_W'(GAIN_Q30) << (ex - GAIN_EXP);
		end else begin
			rk = VEC_W'(GAIN_Q30) >> (GAIN_EXP - ex);
		end
		case (tag_a.off)
			OFF_POS_PI: offv = PI_Q30;
			OFF_NEG_PI: offv = -PI_Q30;
			default:    offv = '0;
		endcase
		a = A_W'(vec_a.z) + offv;
		if (a < 0) begin
			c = HALF_PI_Q30 - a;
		end else if (a > HALF_PI_Q30) begin
			c = TWO_PI_Q30 - a + HALF_PI_Q30;
		end else begin
			c = HALF_PI_Q30 - a;
		end
		tag_m     = tag_a;
		tag_m.ang = (c < 0) ? '0 : c[ANG_W-1:0];
	end

	logic vld_b;
	vec_t vec_b;
	tag_t tag_b;

	tsa_cordic_chain u_chain_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.up_vld (vld_s6),
		.up_vec (vb_s6),
		.up_tag (tag_s6),
		.dn_vld (vld_b),
		.dn_vec (vec_b),
		.dn_tag (tag_b)
	);

	// stage 7: angle select, degree product
	logic [ANG_W-1:0] ang;
	logic [ANG_W-1:0] ang_s7;
	logic [61:0]      plo_s7;
	logic             null_s7;
	logic             vld_s7;

	always_comb begin
		if (mode_q) begin
			ang = tag_b.ang;
		end else begin
			ang = (vec_b.z < 0) ? '0 : ANG_W'(vec_b.z);
		end
	end

	// stage 8: rounding and saturation
	logic [63:0]      p;
	logic [63:0]      rdeg;
	logic [Z_W-1:0]   rrad;
	logic [OUT_W-1:0] r;
	logic [OUT_W-1:0] angle_s8;
	logic             null_s8;
	logic             vld_s8;

	always_comb begin
		p    = 64'(plo_s7) + (ang_s7[ANG_W-1] ? (64'(DEG_Q24) << 32) : 64'd0);
		rdeg = (p + RND_DEG) >> SH_DEG;
		rrad = (Z_W'(ang_s7) + RND_RAD) >> SH_RAD;
		if (deg_q) begin
			r = (rdeg > 64'(ANGLE_MAX)) ? ANGLE_MAX : OUT_W'(rdeg);
		end else begin
			r = (rrad > Z_W'(ANGLE_MAX)) ? ANGLE_MAX : OUT_W'(rrad);
		end
		if (null_s7) begin
			r = '0;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= win.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_a;
			vld_s7 <= vld_b;
			vld_s8 <= vld_s7;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1   <= sx;
			sy_s1   <= sy;
			null_s1 <= |win.special_mask;

			pxl_s2         <= 64'(magx[31:0]) * 64'(inv_x_q);
			pyl_s2         <= 64'(magy[31:0]) * 64'(inv_y_q);
			pxh_s2         <= magx[MAG_W-1:32];
			pyh_s2         <= magy[MAG_W-1:32];
			ax_s2          <= VEC_W'(ax) <<< ASP_SHIFT;
			ay_s2          <= VEC_W'(ay) <<< ASP_SHIFT;
			tag_s2.is_null <= null_s1;
			tag_s2.off     <= off;
			tag_s2.blen    <= REF_BLEN;
			tag_s2.ang     <= '0;

			px_s3  <= PROD_W'(pxl_s2) + {hx, 32'd0};
			py_s3  <= PROD_W'(pyl_s2) + {hy, 32'd0};
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			tag_s3 <= tag_s2;

			px_s4  <= px_s3;
			py_s4  <= py_s3;
			ax_s4  <= ax_s3;
			ay_s4  <= ay_s3;
			tag_s4 <= '{is_null: tag_s3.is_null, off: tag_s3.off, blen: bl,
				ang: tag_s3.ang};

			va_s5.x <= mode_q ? ax_s4 : $signed(nx);
			va_s5.y <= mode_q ? ay_s4 : $signed(ny);
			va_s5.z <= '0;
			tag_s5  <= tag_s4;

			vb_s6.x <= $signed(rk);
			vb_s6.y <= vec_a.x;
			vb_s6.z <= '0;
			tag_s6  <= tag_m;

			ang_s7  <= ang;
			plo_s7  <= 62'(ang[31:0]) * 62'(DEG_Q24);
			null_s7 <= tag_b.is_null;

			angle_s8 <= r;
			null_s8  <= null_s7;
		end
	end

	// output register and skid
	logic             o_vld_q;
	logic [OUT_W-1:0] o_angle_q;
	logic             o_null_q;
	logic             skid_vld_q;
	logic [OUT_W-1:0] skid_angle_q;
	logic             skid_null_q;
	logic             o_free;
	logic             load_skid;

	assign en        = !skid_vld_q;
	assign o_free    = res.ready || !o_vld_q;
	assign load_skid = !o_free && en && vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q    <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (o_free) begin
			o_vld_q    <= skid_vld_q || vld_s8;
			skid_vld_q <= 1'b0;
		end else if (load_skid) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (o_free) begin
			o_angle_q <= skid_vld_q ? skid_angle_q : angle_s8;
			o_null_q  <= skid_vld_q ? skid_null_q : null_s8;
		end
		if (load_skid) begin
			skid_angle_q <= angle_s8;
			skid_null_q  <= null_s8;
		end
	end

	assign win.ready   = en;
	assign res.valid   = o_vld_q;
	assign res.angle   = o_angle_q;
	assign res.is_null = o_null_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> o_vld_q)
		else $error("skid holds a beat while the output register is empty");

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.is_null) |-> (res.angle == '0))
		else $error("null result with non-zero angle");

	a_stall_catch: assert property (@(posedge clk) disable iff (!arst_n)
		(o_vld_q && !res.ready && vld_s8 && !skid_vld_q) |=> skid_vld_q)
		else $error("beat in flight lost during output stall");

endmodule

>>> verif/terrain_slope_aspect_3x3_tb.sv
// ----------------------------------------------------------------------------
// terrain_slope_aspect_3x3_tb: self-checking bench for the slope/aspect block
// Windows go in through the win channel and angles come back on res. A
// scoreboard predicts each angle from its own Horn/CORDIC model. The run steps
// through slope and aspect modes, radians and degrees, and extreme cell sizes,
// under several source-idle and sink-stall mixes.
// ----------------------------------------------------------------------------
module terrain_slope_aspect_3x3_tb;
	import tsa_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 80;

	typedef struct {
		logic signed [ELEV_W-1:0] elev [8];
		logic [MASK_W-1:0]        mask;
	} window_t;

	typedef struct {
		logic [OUT_W-1:0] angle;
		logic             is_null;
	} angle_t;

	class angle_scoreboard;
		angle_t pending[$];
		int     errors;
		int     nulls;
		int     checked;
		bit     aspect_mode;
		bit     degrees;
		bit [31:0] icx;
		bit [31:0] icy;

		function new();
			errors = 0;
			nulls = 0;
			checked = 0;
			aspect_mode = 0;
			degrees = 0;
			icx = 32'd65536;
			icy = 32'd65536;
		endfunction

		function automatic longint rotate(inout longint x, inout longint y);
			longint z, dx, dy;
			z = 0;
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
				end else begin
					x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
				end
			end
			return z;
		endfunction

		function automatic int width_of(logic [127:0] v);
			int n;
			n = 0;
			for (int i = 0; i < 128; i++)
				if (v[i]) n = i + 1;
			return n;
		endfunction

		function automatic logic [63:0] normalise(logic [127:0] p, int sh);
			if (sh > 0) return 64'(p >> sh);
			return 64'(p << (-sh));
		endfunction

		function automatic longint slope_angle(longint sx, longint sy);
			logic [127:0] px, py;
			bit [63:0] rn, rk, g;
			int b, sh;
			longint x, y, z;
			px = {64'd0, 64'(sx < 0 ? -sx : sx)} * {96'd0, icx};
			py = {64'd0, 64'(sy < 0 ? -sy : sy)} * {96'd0, icy};
			b = 20;
			if (width_of(px) > b) b = width_of(px);
			if (width_of(py) > b) b = width_of(py);
			sh = b - 60;
			x = longint'(normalise(px, sh));
			y = longint'(normalise(py, sh));
			rn = normalise(128'd524288, sh);
			void'(rotate(x, y));
			g = 64'(GAIN_Q30);
			rk = (((rn >> 32) * g) << 2) + (((rn & 64'hFFFFFFFF) * g) >> 30);
			y = x;
			x = longint'(rk);
			z = rotate(x, y);
			return z < 0 ? 0 : z;
		endfunction

		function automatic longint compass_angle(longint sx, longint sy);
			longint x, y, off, a, c;
			x = -sx;
			y = sy;
			off = 0;
			if (x < 0) begin
				off = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
				x = -x;
				y = -y;
			end
			x = x <<< ASP_SHIFT;
			y = y <<< ASP_SHIFT;
			a = off + rotate(x, y);
			if (a > longint'(HALF_PI_Q30))
				c = longint'(TWO_PI_Q30) - a + longint'(HALF_PI_Q30);
			else
				c = longint'(HALF_PI_Q30) - a;
			return c < 0 ? 0 : c;
		endfunction

		function void note_window(window_t w);
			angle_t r;
			longint e [8];
			longint sx, sy, a;
			bit [63:0] p;
			r.angle = '0;
			r.is_null = 1'b1;
			if (w.mask == '0) begin
				foreach (e[i]) e[i] = longint'(w.elev[i]);
				// order nw n ne w e sw s se
				sx = (e[2] + 2 * e[4] + e[7]) - (e[0] + 2 * e[3] + e[5]);
				sy = (e[5] + 2 * e[6] + e[7]) - (e[0] + 2 * e[1] + e[2]);
				a = aspect_mode ? compass_angle(sx, sy) : slope_angle(sx, sy);
				if (degrees) p = (64'(a) * 64'(DEG_Q24) + RND_DEG) >> SH_DEG;
				else p = (64'(a) + 64'(RND_RAD)) >> SH_RAD;
				if (p > 64'(ANGLE_MAX)) p = 64'(ANGLE_MAX);
				r.angle = p[OUT_W-1:0];
				r.is_null = 1'b0;
			end
			pending.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check(logic [OUT_W-1:0] angle, logic is_null);
			angle_t x;
			checked++;
			if (is_null) nulls++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected beat angle=%0d null=%0b", angle, is_null));
			end else begin
				x = pending.pop_front();
				if (angle !== x.angle)
					report($sformatf("angle %0d, predicted %0d", angle, x.angle));
				if (is_null !== x.is_null)
					report($sformatf("is_null %0b, predicted %0b", is_null, x.is_null));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tsa_win_if win ();
	tsa_res_if res ();

	terrain_slope_aspect_3x3 DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .win(win.sink), .res(res.source)
	);

	angle_scoreboard sb = new();
	int src_idle;
	int snk_stall;
	int hold_req;
	int hold_left;
	int cycles;
	int sent;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		win.valid = 1'b0;
		win.elev_nw = '0; win.elev_n = '0; win.elev_ne = '0; win.elev_w = '0;
		win.elev_e = '0; win.elev_sw = '0; win.elev_s = '0; win.elev_se = '0;
		win.special_mask = '0;
		res.ready = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// sink side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= snk_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check(res.angle, res.is_null);
	end

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task configure(bit mode, bit deg, bit [31:0] ix, bit [31:0] iy);
		write_reg(CFG_OUTPUT_MODE, 32'(mode));
		write_reg(CFG_IN_DEGREES, 32'(deg));
		write_reg(CFG_INV_CELL_X, ix);
		write_reg(CFG_INV_CELL_Y, iy);
		cfg_we <= 1'b0;
		sb.aspect_mode = mode;
		sb.degrees = deg;
		sb.icx = ix;
		sb.icy = iy;
		@(posedge clk);
	endtask

	task push(window_t w);
		while ($urandom_range(99) < src_idle) begin
			win.valid <= 1'b0;
			@(posedge clk);
		end
		win.valid <= 1'b1;
		win.elev_nw <= w.elev[0]; win.elev_n <= w.elev[1]; win.elev_ne <= w.elev[2];
		win.elev_w <= w.elev[3]; win.elev_e <= w.elev[4]; win.elev_sw <= w.elev[5];
		win.elev_s <= w.elev[6]; win.elev_se <= w.elev[7];
		win.special_mask <= w.mask;
		do @(posedge clk); while (!win.ready);
		sb.note_window(w);
		sent++;
	endtask

	task drain();
		win.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic window_t pattern(int k);
		window_t w;
		logic signed [ELEV_W-1:0] hi, lo;
		hi = 32'sh7FFFFFFF;
		lo = 32'sh80000000;
		foreach (w.elev[i]) w.elev[i] = '0;
		w.mask = '0;
		case (k)
			1: foreach (w.elev[i]) w.elev[i] = hi;
			2: foreach (w.elev[i]) w.elev[i] = lo;
			3: w.elev = '{lo, 0, hi, lo, hi, lo, 0, hi};
			4: w.elev = '{hi, 0, lo, hi, lo, hi, 0, lo};
			5: w.elev = '{lo, lo, lo, 0, 0, hi, hi, hi};
			6: w.elev = '{hi, hi, hi, 0, 0, lo, lo, lo};
			7: w.elev = '{lo, 0, 0, 0, 0, 0, 0, hi};
			8: w.elev[4] = 1;
			9: begin
				w.elev[6] = -3;
				w.mask = 8'h01;
			end
			10: w.mask = 8'h80;
			11: w.mask = 8'hFF;
			default: ;
		endcase
		return w;
	endfunction

	function automatic window_t random_window();
		window_t w;
		logic signed [ELEV_W-1:0] base;
		int spread;
		base = $urandom;
		spread = $urandom_range(3) == 0 ? 2000000 : $urandom_range(1, 300);
		foreach (w.elev[i]) begin
			if ($urandom_range(4) == 0)
				w.elev[i] = $urandom;
			else
				w.elev[i] = base + $urandom_range(2 * spread) - spread;
		end
		w.mask = ($urandom_range(7) == 0) ? MASK_W'($urandom_range(1, 255)) : '0;
		return w;
	endfunction

	initial begin
		int idle_src [4] = '{0, 65, 0, 38};
		int idle_snk [4] = '{0, 0, 65, 38};
		hold_req = 0;
		hold_left = 0;
		cycles = 0;
		sent = 0;
		src_idle = 0;
		snk_stall = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed windows, slope in radians then compass in degrees
		for (int k = 0; k < 12; k++) push(pattern(k));
		drain();
		configure(1'b1, 1'b1, 32'd65536, 32'd65536);
		for (int k = 0; k < 12; k++) push(pattern(k));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: configure(1'b0, 1'b0, 32'd65536, 32'd65536);
				1: configure(1'b1, 1'b1, $urandom, $urandom);
				2: configure(1'b0, 1'b1, 32'd0, 32'hFFFFFFFF);
				3: configure(1'b1, 1'b0, 32'd1, 32'd0);
				4: configure(1'b0, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF);
				5: configure(1'b0, 1'b1, $urandom_range(1, 65536), $urandom_range(1, 65536));
				6: configure(1'b1, 1'b1, 32'd0, 32'd0);
				default: configure(1'b0, 1'b0, $urandom, $urandom_range(0, 4096));
			endcase
			src_idle = idle_src[ph % 4];
			snk_stall = idle_snk[ph % 4];
			if (ph == 0) hold_req = 400;
			for (int n = 0; n < 103; n++) begin
				if (ph == 5 && n == 50) begin
					win.valid <= 1'b0;
					while (sb.pending.size() != 0) @(posedge clk);
				end
				if ($urandom_range(15) == 0) begin
					src_idle = 0;
					snk_stall = 0;
				end else if ($urandom_range(15) == 0) begin
					src_idle = idle_src[ph % 4];
					snk_stall = idle_snk[ph % 4];
				end
				push(random_window());
			end
			drain();
		end

		$display("covered %0d windows (%0d null) in slope and compass modes,", sent, sb.nulls);
		$display("radians and degrees, extreme cell sizes and four stall mixes");
		if (sb.errors == 0 && sb.checked == sent) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d of %0d beats back", sb.errors, sb.checked, sent);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
